// ===== hw/rtl/svl_pkg.sv =====
package svl_pkg;

  // Fixed-point constants
  localparam logic [30:0] TargetQ132  = 31'd1078036791;    // 0.251 in Q1.32
  localparam logic [46:0] DivDividend = {TargetQ132, 16'h0000};
  localparam logic [17:0] GainMax     = 18'd260833;        // 3.98 in Q3.16
  localparam logic [17:0] GainMin     = 18'd32768;         // 0.5 in Q3.16
  localparam logic [17:0] GainUnity   = 18'd65536;         // 1.0 in Q3.16
  localparam logic [4:0]  DivLastBit  = 5'd18;             // quotient bits 18..0

  // Configuration register indexes
  localparam logic [1:0] RegLevelerOn = 2'd0;
  localparam logic [1:0] RegIntensity = 2'd1;
  localparam logic [1:0] RegAttack    = 2'd2;
  localparam logic [1:0] RegRelease   = 2'd3;

  localparam int unsigned PcW = 4;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ENV_MUL,
    OP_ENV_UPD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_CLAMP,
    OP_PULL_MUL,
    OP_PULL_ADD,
    OP_MUL_L,
    OP_MUL_R,
    OP_SAT_R,
    OP_PASS,
    OP_EMIT
  } op_e;

  // Jump conditions
  typedef enum logic [2:0] {
    JC_NEXT,      // fall through
    JC_WAIT_IN,   // hold until a word is taken
    JC_IF_OFF,    // go to target when leveling is off
    JC_LOOP,      // go to target while the divider has bits left
    JC_WAIT_OUT,  // hold while the output word is stalled, then go to target
    JC_GOTO       // go to target
  } jc_e;

  typedef struct packed {
    op_e            op;
    jc_e            jc;
    logic [PcW-1:0] target;
  } ucode_t;

  // Control from sequencer to datapath
  typedef struct packed {
    op_e  op;
    logic take;
  } ctrl_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic div_done;
  } stat_t;

  // Program store
  function automatic ucode_t svl_ucode(input logic [PcW-1:0] pc);
    ucode_t w;
    case (pc)
      4'd0:    w = '{OP_NOP,      JC_WAIT_IN,  4'd0};
      4'd1:    w = '{OP_NOP,      JC_IF_OFF,   4'd13};
      4'd2:    w = '{OP_ENV_MUL,  JC_NEXT,     4'd0};
      4'd3:    w = '{OP_ENV_UPD,  JC_NEXT,     4'd0};
      4'd4:    w = '{OP_DIV_INIT, JC_NEXT,     4'd0};
      4'd5:    w = '{OP_DIV_STEP, JC_LOOP,     4'd5};
      4'd6:    w = '{OP_CLAMP,    JC_NEXT,     4'd0};
      4'd7:    w = '{OP_PULL_MUL, JC_NEXT,     4'd0};
      4'd8:    w = '{OP_PULL_ADD, JC_NEXT,     4'd0};
      4'd9:    w = '{OP_MUL_L,    JC_NEXT,     4'd0};
      4'd10:   w = '{OP_MUL_R,    JC_NEXT,     4'd0};
      4'd11:   w = '{OP_SAT_R,    JC_NEXT,     4'd0};
      4'd12:   w = '{OP_EMIT,     JC_WAIT_OUT, 4'd0};
      4'd13:   w = '{OP_PASS,     JC_GOTO,     4'd12};
      default: w = '{OP_NOP,      JC_GOTO,     4'd0};
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/svl_datapath.sv =====
module svl_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  svl_pkg::ctrl_t      ctrl_i,
  input  logic signed [23:0]  left_in_i,
  input  logic signed [23:0]  right_in_i,
  input  logic [15:0]         intensity_i,
  input  logic [31:0]         attack_coef_i,
  input  logic [31:0]         release_coef_i,
  output svl_pkg::stat_t      stat_o,
  output logic signed [23:0]  left_res_o,
  output logic signed [23:0]  right_res_o
);
  import svl_pkg::*;

  // Saturate a magnitude with sign to a 24-bit sample
  function automatic logic [23:0] sat24(input logic neg, input logic [25:0] mag);
    logic [23:0] r;
    if (!neg) begin
      r = (mag > 26'd8388607) ? 24'h7FFFFF : mag[23:0];
    end else begin
      r = (mag > 26'd8388608) ? 24'h800000 : (~mag[23:0] + 24'd1);
    end
    return r;
  endfunction

  logic signed [23:0] l_q, r_q;
  logic [32:0] env_q;
  logic [64:0] prod_q;
  logic [46:0] rem_q;
  logic [50:0] dvs_q;
  logic [18:0] quo_q;
  logic [4:0]  cnt_q;
  logic        gneg_q;
  logic [17:0] gmag_q;
  logic [17:0] gain_q;
  logic [23:0] lres_q, rres_q;

  logic [23:0] abs_l, abs_r;
  logic [32:0] mono, diff, step, env_n;
  logic        up, div_ge;
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] mul_p;
  logic [17:0] g_clamp, pull;

  // Level and envelope direction
  assign abs_l = l_q[23] ? (~l_q + 24'd1) : l_q;
  assign abs_r = r_q[23] ? (~r_q + 24'd1) : r_q;
  assign mono  = {({1'b0, abs_l} + {1'b0, abs_r}), 8'h00};
  assign up    = mono > env_q;
  assign diff  = up ? (mono - env_q) : (env_q - mono);

  // Envelope step, floored at one least step
  assign step  = prod_q[64:32];
  always_comb begin
    env_n = up ? (env_q + step) : (env_q - step);
    if (env_n == 33'd0) env_n = 33'd1;
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = {9'h0, abs_l};
    mul_b = {14'h0, gain_q};
    unique case (ctrl_i.op)
      OP_ENV_MUL: begin
        mul_a = diff;
        mul_b = up ? attack_coef_i : release_coef_i;
      end
      OP_PULL_MUL: begin
        mul_a = {15'h0, gmag_q};
        mul_b = {16'h0, intensity_i};
      end
      OP_MUL_R: mul_a = {9'h0, abs_r};
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Divider compare and gain clamp
  assign div_ge = {4'h0, rem_q} >= dvs_q;

  always_comb begin
    if (quo_q[18] || (quo_q[17:0] > GainMax)) begin
      g_clamp = GainMax;
    end else if (quo_q[17:0] < GainMin) begin
      g_clamp = GainMin;
    end else begin
      g_clamp = quo_q[17:0];
    end
  end

  assign pull = prod_q[33:16];

  // Envelope state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q <= '0;
    end else if (ctrl_i.op == OP_ENV_UPD) begin
      env_q <= env_n;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.take) begin
      l_q <= left_in_i;
      r_q <= right_in_i;
    end
    unique case (ctrl_i.op)
      OP_ENV_MUL, OP_PULL_MUL, OP_MUL_L: prod_q <= mul_p;
      OP_DIV_INIT: begin
        rem_q <= DivDividend;
        dvs_q <= {env_q, 18'h0};
        quo_q <= '0;
        cnt_q <= DivLastBit;
      end
      OP_DIV_STEP: begin
        if (div_ge) rem_q <= rem_q - dvs_q[46:0];
        quo_q <= {quo_q[17:0], div_ge};
        dvs_q <= {1'b0, dvs_q[50:1]};
        cnt_q <= cnt_q - 5'd1;
      end
      OP_CLAMP: begin
        gneg_q <= g_clamp < GainUnity;
        gmag_q <= (g_clamp < GainUnity) ? (GainUnity - g_clamp) : (g_clamp - GainUnity);
      end
      OP_PULL_ADD: gain_q <= gneg_q ? (GainUnity - pull) : (GainUnity + pull);
      OP_MUL_R: begin
        lres_q <= sat24(l_q[23], prod_q[41:16]);
        prod_q <= mul_p;
      end
      OP_SAT_R: rres_q <= sat24(r_q[23], prod_q[41:16]);
      OP_PASS: begin
        lres_q <= l_q;
        rres_q <= r_q;
      end
      default: ;
    endcase
  end

  assign stat_o.div_done = (cnt_q == 5'd0);
  assign left_res_o      = lres_q;
  assign right_res_o     = rres_q;

endmodule

// ===== hw/rtl/stereo_volume_leveler.sv =====
// Stereo volume leveler, microcoded: a 14-step program drives one shared datapath.
// Leveling on: the gain comes from the 19-step restoring divider; one word is in flight
// at a time, so a new word is taken only after the last one is emitted.
// Leveling off: the input word is passed through unchanged, also one word at a time.
// A finished word waits in the output register. Reset is asynchronous, active low:
// envelope, program step and output valid cleared, configuration registers to defaults.
module stereo_volume_leveler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // left_in [23:0], right_in [47:24]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // left_out [23:0], right_out [47:24]
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import svl_pkg::*;

  logic            on_q;
  logic [15:0]     intensity_q;
  logic [31:0]     attack_q, release_q;
  logic [PcW-1:0]  pc_q, pc_d;
  logic            out_valid_q;
  logic [47:0]     out_data_q;
  ucode_t          uw;
  ctrl_t           ctrl;
  stat_t           stat;
  logic            take, out_busy, emit;
  logic signed [23:0] lres, rres;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q        <= 1'b1;
      intensity_q <= 16'd32768;
      attack_q    <= 32'd596482;
      release_q   <= 32'd111847;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegLevelerOn: on_q        <= cfg_data_i[0];
        RegIntensity: intensity_q <= cfg_data_i[15:0];
        RegAttack:    attack_q    <= cfg_data_i;
        RegRelease:   release_q   <= cfg_data_i;
      endcase
    end
  end

  // Fetch the control word and handshake
  assign uw            = svl_ucode(pc_q);
  assign s_axis_tready = (uw.jc == JC_WAIT_IN);
  assign take          = s_axis_tvalid && s_axis_tready;
  assign out_busy      = out_valid_q && !m_axis_tready;
  assign emit          = (uw.op == OP_EMIT) && !out_busy;
  assign ctrl.op       = uw.op;
  assign ctrl.take     = take;

  // Next step
  always_comb begin
    pc_d = pc_q + 4'd1;
    unique case (uw.jc)
      JC_NEXT:     pc_d = pc_q + 4'd1;
      JC_WAIT_IN:  if (!take) pc_d = pc_q;
      JC_IF_OFF:   if (!on_q) pc_d = uw.target;
      JC_LOOP:     if (!stat.div_done) pc_d = uw.target;
      JC_WAIT_OUT: pc_d = out_busy ? pc_q : uw.target;
      JC_GOTO:     pc_d = uw.target;
      default:     pc_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) out_data_q <= {rres, lres};
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  svl_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .left_in_i      (s_axis_tdata[23:0]),
    .right_in_i     (s_axis_tdata[47:24]),
    .intensity_i    (intensity_q),
    .attack_coef_i  (attack_q),
    .release_coef_i (release_q),
    .stat_o         (stat),
    .left_res_o     (lres),
    .right_res_o    (rres)
  );

endmodule
